FILE: sv/srl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srl_pkg: shared types and codes for the sequential record list
// Operation and status codes, field widths, the stored record and the
// result bundle passed from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package srl_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int FUNC_W   = 3;
  localparam int CODE_W   = 32;
  localparam int NAME_W   = 64;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int CNT_W    = 7;

  // stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 128;  // key, code, name
  localparam int OUT_TDATA_W = 112;  // position, old code, old name, count

  localparam logic [FUNC_W-1:0] OP_CLEAR   = 3'd0;
  localparam logic [FUNC_W-1:0] OP_APPEND  = 3'd1;
  localparam logic [FUNC_W-1:0] OP_PREPEND = 3'd2;
  localparam logic [FUNC_W-1:0] OP_DROP_HD = 3'd3;
  localparam logic [FUNC_W-1:0] OP_DROP_TL = 3'd4;
  localparam logic [FUNC_W-1:0] OP_UPDATE  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic signed [CODE_W-1:0] code;
    logic [NAME_W-1:0]        name;
  } rec_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [POS_W-1:0]         pos;
    logic signed [CODE_W-1:0] old_code;
    logic [NAME_W-1:0]        old_name;
    logic [CNT_W-1:0]         count;
  } res_t;

endpackage

FILE: sv/srl_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srl_store: record memory
// Single write port and single registered read port; read data appears in the cycle after the read.
// ----------------------------------------------------------------------------
module srl_store #(
  parameter int CAPACITY = srl_pkg::CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  srl_pkg::rec_t wr_rec,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output srl_pkg::rec_t rd_rec
);
  import srl_pkg::*;

  rec_t mem [CAPACITY];
  rec_t rd_rec_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rec_r <= mem[rd_addr];
    end
  end

  assign rd_rec = rd_rec_r;

endmodule

FILE: sv/srl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srl_ctrl: list sequencer
// Keeps the list as a ring in the record memory (head pointer plus count),
// runs one operation at a time and scans the ring for update lookups.
// ----------------------------------------------------------------------------
module srl_ctrl #(
  parameter int CAPACITY = srl_pkg::CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [srl_pkg::FUNC_W-1:0]         func,
  input  logic signed [srl_pkg::CODE_W-1:0]  search_key,
  input  logic signed [srl_pkg::CODE_W-1:0]  new_code,
  input  logic [srl_pkg::NAME_W-1:0]         new_name,
  output logic                               res_valid,
  input  logic                               res_ready,
  output srl_pkg::res_t                      res,
  output logic                               wr_en,
  output logic [AW-1:0]                      wr_addr,
  output srl_pkg::rec_t                      wr_rec,
  output logic                               rd_en,
  output logic [AW-1:0]                      rd_addr,
  input  srl_pkg::rec_t                      rd_rec
);
  import srl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_DONE} state_t;

  state_t                   state_r, state_nxt;
  logic [AW-1:0]            head_r, head_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [FUNC_W-1:0]        op_r;
  logic signed [CODE_W-1:0] key_r;
  rec_t                     new_rec_r;
  logic [CW-1:0]            rd_idx_r, rd_idx_nxt;
  logic                     cmp_vld_r, cmp_vld_nxt;
  logic [CW-1:0]            cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0]            cmp_addr_r, cmp_addr_nxt;
  res_t                     res_r, res_nxt;

  // ring index add, both operands below CAPACITY
  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(CAPACITY)) begin
      s = s - (AW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  logic full, empty;
  assign full  = (count_r == CW'(CAPACITY));
  assign empty = (count_r == '0);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    rd_idx_nxt   = rd_idx_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    cmp_addr_nxt = cmp_addr_r;
    res_nxt      = res_r;
    wr_en        = 1'b0;
    wr_addr      = head_r;
    wr_rec       = new_rec_r;
    rd_en        = 1'b0;
    rd_addr      = ring_add(head_r, rd_idx_r[AW-1:0]);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        res_nxt.status   = ST_OK;
        res_nxt.pos      = '0;
        res_nxt.old_code = '0;
        res_nxt.old_name = '0;
        state_nxt        = S_DONE;
        case (op_r)
          OP_CLEAR: begin
            count_nxt = '0;
          end
          OP_APPEND: begin
            if (full) begin
              res_nxt.status = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = ring_add(head_r, count_r[AW-1:0]);
              count_nxt = count_r + CW'(1);
            end
          end
          OP_PREPEND: begin
            if (full) begin
              res_nxt.status = ST_FULL;
            end else begin
              head_nxt  = (head_r == '0) ? AW'(CAPACITY - 1) : head_r - AW'(1);
              wr_en     = 1'b1;
              wr_addr   = head_nxt;
              count_nxt = count_r + CW'(1);
            end
          end
          OP_DROP_HD: begin
            if (empty) begin
              res_nxt.status = ST_EMPTY;
            end else begin
              head_nxt  = ring_add(head_r, AW'(1));
              count_nxt = count_r - CW'(1);
            end
          end
          OP_DROP_TL: begin
            if (empty) begin
              res_nxt.status = ST_EMPTY;
            end else begin
              count_nxt = count_r - CW'(1);
            end
          end
          OP_UPDATE: begin
            if (empty) begin
              res_nxt.status = ST_MISSING;
            end else begin
              rd_idx_nxt = '0;
              state_nxt  = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end

      S_SCAN: begin
        // issue one read per cycle, compare what came back last cycle
        if (rd_idx_r < count_r) begin
          rd_en        = 1'b1;
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = rd_idx_r;
          cmp_addr_nxt = rd_addr;
          rd_idx_nxt   = rd_idx_r + CW'(1);
        end
        if (cmp_vld_r) begin
          if (rd_rec.code == key_r) begin
            wr_en            = 1'b1;
            wr_addr          = cmp_addr_r;
            res_nxt.pos      = POS_W'(cmp_idx_r);
            res_nxt.old_code = rd_rec.code;
            res_nxt.old_name = rd_rec.name;
            cmp_vld_nxt      = 1'b0;
            state_nxt        = S_DONE;
          end else if (cmp_idx_r == count_r - CW'(1)) begin
            res_nxt.status = ST_MISSING;
            cmp_vld_nxt    = 1'b0;
            state_nxt      = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res_nxt.count = CNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r           <= func;
      key_r          <= search_key;
      new_rec_r.code <= new_code;
      new_rec_r.name <= new_name;
    end
    rd_idx_r   <= rd_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    cmp_addr_r <= cmp_addr_nxt;
    res_r      <= res_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("list count above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r < AW'(CAPACITY) || CAPACITY == (1 << AW))
    else $error("head pointer outside ring");

  a_count_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_EXEC |=> $stable(count_r) && $stable(head_r))
    else $error("list pointers moved outside execute cycle");

  a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_EXEC || (state_r == S_SCAN && cmp_vld_r)))
    else $error("memory write outside an operation");

endmodule

FILE: sv/sequential_record_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_record_list: ordered list of signed-code / name records
// Holds up to CAPACITY records in a ring buffer in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one operation per item. in_tuser carries the
//   operation (clear, append, prepend, remove first, remove last, update by
//   code); in_tdata carries search key, new code and new name.
//   Output channel out_*: exactly one result item per input item, in order.
//   out_tuser is the status; out_tdata holds position, old record and count.
//   Prepend and remove-first move the ring head pointer, so no entry is ever
//   physically shifted.
//   Timing: one item at a time. Clear, append, prepend and the removes
//   go from acceptance through the execute state to the result state.
//   Update scans the ring through the single memory read port, one entry
//   per cycle, and stops at the first hit or after the last entry; on an
//   empty list it goes straight to a miss result.
//   Reset: the list is empty, the output register is empty; memory contents
//   are not cleared since only entries below the count are ever read.
//   Stall: a result waits in the output register while out_tready is low;
//   the next item is still accepted and worked on, and its result holds in
//   the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module sequential_record_list #(
  parameter int CAPACITY = srl_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [31:0] search_key, [63:32] new_code, [127:64] new_name
  input  logic [srl_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [2:0] func
  input  logic [srl_pkg::FUNC_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [5:0] found_position, [37:6] old_code, [101:38] old_name,
  // [108:102] entry_count, [111:109] zero
  output logic [srl_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [1:0] status
  output logic [srl_pkg::STATUS_W-1:0]        out_tuser
);
  import srl_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  // sequencer <-> memory
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  rec_t          wr_rec, rd_rec;

  // sequencer -> output register
  logic res_valid, res_ready;
  res_t res;

  // output register
  logic out_vld_r;
  res_t out_res_r;

  srl_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .func       (in_tuser),
    .search_key (in_tdata[CODE_W-1:0]),
    .new_code   (in_tdata[2*CODE_W-1:CODE_W]),
    .new_name   (in_tdata[2*CODE_W+NAME_W-1:2*CODE_W]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_rec     (wr_rec),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_rec     (rd_rec)
  );

  srl_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_rec  (wr_rec),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_rec  (rd_rec)
  );

  // take a new result when the register is empty or being drained
  assign res_ready = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_ready) begin
      out_vld_r <= res_valid;
    end
  end

  // hold the payload while stalled, load with each new result
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {(OUT_TDATA_W - POS_W - CODE_W - NAME_W - CNT_W)'(0),
                       out_res_r.count, out_res_r.old_name,
                       out_res_r.old_code, out_res_r.pos};

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sequential record list
// Drives list operations into the input stream and mirrors every operation
// in a local copy of the list, which yields the status, position, replaced
// record and count for each item. A monitor matches each result item
// against the oldest prediction. Directed checks come first: the empty
// list, extreme codes and names, duplicate keys, the full list. Random
// traffic follows in four flow-control phases.
// ----------------------------------------------------------------------------
module tb_top;
  import srl_pkg::*;

  localparam int LIST_CAP     = CAPACITY_DEF;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 2 * LIST_CAP + 16;

  // the two func codes the block must ignore
  localparam logic [FUNC_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] OP_SPARE_HI = 3'd7;

  localparam logic signed [CODE_W-1:0] CODE_MIN = 32'sh8000_0000;
  localparam logic signed [CODE_W-1:0] CODE_MAX = 32'sh7FFF_FFFF;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [FUNC_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;

  // result fields, unpacked from the lowest bit up
  wire [POS_W-1:0]         got_pos   = out_tdata[5:0];
  wire signed [CODE_W-1:0] got_code  = out_tdata[37:6];
  wire [NAME_W-1:0]        got_name  = out_tdata[101:38];
  wire [CNT_W-1:0]         got_count = out_tdata[108:102];

  // mirror of the list contents
  logic signed [CODE_W-1:0] list_codes [LIST_CAP];
  logic [NAME_W-1:0]        list_names [LIST_CAP];
  int                       list_count;

  res_t pending_results[$];
  res_t oldest_result;
  int   mismatch_count;
  int   cycle_count;
  int   send_idle_pct;
  int   recv_stall_pct;

  sequential_record_list #(
    .CAPACITY (LIST_CAP)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Hard stop: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sequential_record_list test failed");
      $finish;
    end
  end

  // Receiver back-pressure: drop out_tready at the current stall rate.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Apply one operation to the mirror and return the result it must produce.
  function automatic res_t apply_list_op(input logic [FUNC_W-1:0] op,
                                         input logic signed [CODE_W-1:0] key,
                                         input logic signed [CODE_W-1:0] code,
                                         input logic [NAME_W-1:0] name);
    res_t r;
    int   hit;
    r   = '0;
    hit = -1;
    case (op)
      OP_CLEAR: begin
        list_count = 0;
      end
      OP_APPEND: begin
        if (list_count >= LIST_CAP) begin
          r.status = ST_FULL;
        end else begin
          list_codes[list_count] = code;
          list_names[list_count] = name;
          list_count++;
        end
      end
      OP_PREPEND: begin
        if (list_count >= LIST_CAP) begin
          r.status = ST_FULL;
        end else begin
          // shift every entry up one place, then insert at the head
          for (int i = list_count; i > 0; i--) begin
            list_codes[i] = list_codes[i-1];
            list_names[i] = list_names[i-1];
          end
          list_codes[0] = code;
          list_names[0] = name;
          list_count++;
        end
      end
      OP_DROP_HD: begin
        if (list_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i + 1 < list_count; i++) begin
            list_codes[i] = list_codes[i+1];
            list_names[i] = list_names[i+1];
          end
          list_count--;
        end
      end
      OP_DROP_TL: begin
        if (list_count == 0) r.status = ST_EMPTY;
        else list_count--;
      end
      OP_UPDATE: begin
        // first match from the head wins
        for (int i = 0; i < list_count; i++) begin
          if (hit < 0 && list_codes[i] == key) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_MISSING;
        end else begin
          r.pos      = POS_W'(hit);
          r.old_code = list_codes[hit];
          r.old_name = list_names[hit];
          list_codes[hit] = code;
          list_names[hit] = name;
        end
      end
      default: ;  // spare codes leave the list alone
    endcase
    r.count = CNT_W'(list_count);
    return r;
  endfunction

  // Send one item: idle at the sender rate, hold tvalid until accepted,
  // then record the prediction. tvalid is lowered only by the next idle
  // cycle or the final drain, so it never gets two updates in one step.
  task automatic push_list_op(input logic [FUNC_W-1:0] op,
                              input logic signed [CODE_W-1:0] key,
                              input logic signed [CODE_W-1:0] code,
                              input logic [NAME_W-1:0] name);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {name, code, key};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_list_op(op, key, code, name));
  endtask

  task automatic note_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
  endtask

  // Result monitor: compare each accepted result item with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", '0, {62'd0, out_tuser});
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_tuser !== oldest_result.status)
          note_mismatch("status", 64'(oldest_result.status), 64'(out_tuser));
        if (got_pos !== oldest_result.pos)
          note_mismatch("found_position", 64'(oldest_result.pos), 64'(got_pos));
        if (got_code !== oldest_result.old_code)
          note_mismatch("old_code", 64'(oldest_result.old_code), 64'(got_code));
        if (got_name !== oldest_result.old_name)
          note_mismatch("old_name", oldest_result.old_name, got_name);
        if (got_count !== oldest_result.count)
          note_mismatch("entry_count", 64'(oldest_result.count), 64'(got_count));
      end
    end
  end

  // Random field content: extremes, a small pool for duplicate codes, or anything.
  function automatic logic signed [CODE_W-1:0] rand_code();
    int pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0: return CODE_MIN;
      1: return CODE_MAX;
      2: return '0;
      3: return '1;
      default: begin
        if (pick < 8) return $urandom_range(0, 7);
        return $urandom;
      end
    endcase
  endfunction

  function automatic logic [NAME_W-1:0] rand_name();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Update keys mostly hit a code that is in the list.
  function automatic logic signed [CODE_W-1:0] pick_key();
    if (list_count > 0 && $urandom_range(0, 99) < 70)
      return list_codes[$urandom_range(0, list_count - 1)];
    return rand_code();
  endfunction

  // Removes, update and clear on an empty list, plus the spare codes.
  task automatic test_empty_list();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    push_list_op(OP_DROP_HD, '0, '0, '0);
    push_list_op(OP_DROP_TL, '1, '1, '1);
    push_list_op(OP_UPDATE, '0, CODE_MAX, '1);
    push_list_op(OP_CLEAR, CODE_MIN, CODE_MIN, '0);
    push_list_op(OP_SPARE_LO, '0, '0, '0);
    push_list_op(OP_SPARE_HI, CODE_MAX, CODE_MAX, '1);
  endtask

  // Extreme codes and names, duplicates, hits and misses, clear.
  task automatic test_record_ops();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    push_list_op(OP_APPEND, '0, CODE_MIN, '0);
    push_list_op(OP_PREPEND, '0, CODE_MAX, '1);
    push_list_op(OP_APPEND, '0, '1, 64'h0123_4567_89AB_CDEF);
    push_list_op(OP_APPEND, '0, 32'sd5, 64'hFEDC_BA98_7654_3210);
    push_list_op(OP_APPEND, '0, 32'sd5, 64'h5555_AAAA_5555_AAAA);
    // duplicate codes: the first hit is replaced, then the second
    push_list_op(OP_UPDATE, 32'sd5, '0, 64'h8000_0000_0000_0001);
    push_list_op(OP_UPDATE, 32'sd5, CODE_MIN, '1);
    push_list_op(OP_UPDATE, 32'sd12345, '0, '0);
    push_list_op(OP_UPDATE, CODE_MAX, 32'sd7, 64'h00FF_00FF_00FF_00FF);
    push_list_op(OP_DROP_HD, '0, '0, '0);
    push_list_op(OP_DROP_TL, '0, '0, '0);
    push_list_op(OP_SPARE_LO, CODE_MIN, '0, '1);
    push_list_op(OP_CLEAR, '0, '0, '0);
    // stale entries past the count must not match
    push_list_op(OP_UPDATE, CODE_MIN, '0, '0);
    push_list_op(OP_APPEND, '0, CODE_MAX, '1);
  endtask

  // Fill to capacity with distinct codes, hit the last slot, overflow, drain.
  task automatic test_full_list();
    int k;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    push_list_op(OP_CLEAR, '0, '0, '0);
    k = 0;
    while (list_count < LIST_CAP) begin
      push_list_op(k[0] ? OP_PREPEND : OP_APPEND, rand_code(),
                   {k[7:0], 24'($urandom)}, rand_name());
      k++;
    end
    push_list_op(OP_UPDATE, list_codes[LIST_CAP-1], rand_code(), rand_name());
    push_list_op(OP_APPEND, '0, rand_code(), rand_name());
    push_list_op(OP_PREPEND, '0, rand_code(), rand_name());
    // a miss on a full list scans every entry
    push_list_op(OP_UPDATE, {8'hFF, 24'($urandom)}, rand_code(), rand_name());
    k = 0;
    while (list_count > 0) begin
      push_list_op(k[0] ? OP_DROP_TL : OP_DROP_HD, rand_code(), rand_code(), rand_name());
      k++;
    end
    push_list_op(OP_DROP_HD, '0, '0, '0);
  endtask

  // Random operations; the grow/shrink bias drifts every few dozen items so
  // the list sweeps between empty and nearly full.
  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    int grow_pct;
    int add_pct;
    int drop_pct;
    int roll;
    logic [FUNC_W-1:0] op;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    grow_pct = 50;
    for (int k = 0; k < n_items; k++) begin
      if (k % 40 == 0) grow_pct = $urandom_range(15, 95);
      add_pct  = grow_pct * 6 / 10;
      drop_pct = (100 - grow_pct) * 6 / 10;
      roll     = $urandom_range(0, 99);
      if (roll < 1) op = OP_CLEAR;
      else if (roll < 1 + add_pct) op = $urandom_range(0, 1) ? OP_APPEND : OP_PREPEND;
      else if (roll < 1 + add_pct + drop_pct)
        op = $urandom_range(0, 1) ? OP_DROP_HD : OP_DROP_TL;
      else op = OP_UPDATE;
      push_list_op(op, pick_key(), rand_code(), rand_name());
    end
  endtask

  // Stop sending, wait for every prediction to be matched, then let the
  // block settle before the final check.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = OP_CLEAR;
    list_count     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // hold reset, then release it for good
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_record_ops();
    test_full_list();
    test_random_traffic(160, 0, 0);
    test_random_traffic(160, 77, 0);
    test_random_traffic(160, 0, 77);
    test_random_traffic(160, 36, 36);
    drain_results();

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("sequential_record_list test passed");
    end else begin
      $display("sequential_record_list test failed");
    end
    $finish;
  end

endmodule
